// ===== sv/assert_macros.svh =====
// assertion macros used by the port checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define APF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define APF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/apf_pkg.sv =====
// shared constants and the output item type of the keying modulator
// no dependencies
package apf_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int FIFO_DEPTH         = 4;
    localparam int SIB_W              = 16;
    localparam int MAG_W              = 15;
    localparam int SAMPLE_W           = 17;
    localparam int STATE_W_DEF        = SIB_W + 1 + 3 * PHASE_BITS_DEF;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       bit_taken;
        logic                       last;
    } t_out_item;

endpackage

// ===== sv/ask_psk_fsk_keying_modulator.sv =====
// top level of the ask / psk / fsk keying modulator with nco phase accumulators
// depends on apf_pkg, apf_state_mem, apf_sine_rom, apf_out_fifo
//
//   channel   direction  handshake               payload
//   in        input      i_in_valid / o_in_stall  i_data_bit, i_final_req
//   out       output     o_out_valid / i_out_stall o_sample, o_bit_taken, o_last
//   config    input      apb psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// one item per clock sustained while the output buffer has room; the state
// read-modify-write and the sine rom read happen at the accept edge, the result
// is registered in the rom stage, then enters the output buffer and leaves from there
// the state word is rewritten every accepted item through a forwarded
// read-modify-write, which sets the one-item-per-cycle loop
// reset clears the state word directly, no clearing pass
// the input stalls only when the items in the four-entry output buffer and the
// rom stage together fill it, so a waiting result does not block the next item
module ask_psk_fsk_keying_modulator
    import apf_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input items
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_data_bit,
    input  logic                       i_final_req,
    // result items
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_bit_taken,
    output logic                       o_last,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [4:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int A       = SINE_ADDR_BITS;
    localparam int ST_W    = SIB_W + 1 + 3 * PHASE_BITS;
    localparam int CW      = $clog2(FIFO_DEPTH + 1);

    // keying kinds
    localparam logic [1:0] MODE_ASK = 2'd0;
    localparam logic [1:0] MODE_PSK = 2'd1;
    localparam logic [1:0] MODE_FSK = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_SPB       = 3'd1;
    localparam logic [2:0] REG_CARRIER   = 3'd2;
    localparam logic [2:0] REG_TONE_ZERO = 3'd3;
    localparam logic [2:0] REG_TONE_ONE  = 3'd4;
    localparam logic [2:0] REG_AMP_ZERO  = 3'd5;
    localparam logic [2:0] REG_AMP_ONE   = 3'd6;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  r_mode;
    logic [15:0] r_spb;
    logic [31:0] r_carrier_step;
    logic [31:0] r_tone_zero_step;
    logic [31:0] r_tone_one_step;
    logic [1:0]  r_amp_zero;
    logic [1:0]  r_amp_one;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_ASK;
            r_spb            <= 16'd2000;
            r_carrier_step   <= 32'd4294967;
            r_tone_zero_step <= 32'd6442451;
            r_tone_one_step  <= 32'd8589935;
            r_amp_zero       <= 2'd1;
            r_amp_one        <= 2'd2;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODE:      r_mode           <= pwdata[1:0];
                REG_SPB:       r_spb            <= pwdata[15:0];
                REG_CARRIER:   r_carrier_step   <= pwdata;
                REG_TONE_ZERO: r_tone_zero_step <= pwdata;
                REG_TONE_ONE:  r_tone_one_step  <= pwdata;
                REG_AMP_ZERO:  r_amp_zero       <= pwdata[1:0];
                REG_AMP_ONE:   r_amp_one        <= pwdata[1:0];
                default:       ; // writes past the register list are dropped
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MODE:      prdata = {30'd0, r_mode};
            REG_SPB:       prdata = {16'd0, r_spb};
            REG_CARRIER:   prdata = r_carrier_step;
            REG_TONE_ZERO: prdata = r_tone_zero_step;
            REG_TONE_ONE:  prdata = r_tone_one_step;
            REG_AMP_ZERO:  prdata = {30'd0, r_amp_zero};
            REG_AMP_ONE:   prdata = {30'd0, r_amp_one};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // state word: bit counter, held bit, three phase accumulators
    // ------------------------------------------------------------------
    logic [ST_W-1:0]       cur_state;
    logic [ST_W-1:0]       n_state;
    logic [SIB_W-1:0]      cur_sib;
    logic                  cur_held;
    logic [PHASE_BITS-1:0] cur_carrier;
    logic [PHASE_BITS-1:0] cur_zero;
    logic [PHASE_BITS-1:0] cur_one;
    logic                  in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    apf_state_mem #(
        .WIDTH (ST_W)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_acc),
        .i_wr_data (n_state),
        .o_rd_data (cur_state)
    );

    assign {cur_sib, cur_held, cur_carrier, cur_zero, cur_one} = cur_state;

    // bit fetch at the start of every bit period
    logic             taken;
    logic             held_eff;
    logic [SIB_W:0]   sib_inc;
    logic [SIB_W-1:0] sib_nxt;

    assign taken    = (cur_sib == '0);
    assign held_eff = taken ? i_data_bit : cur_held;
    assign sib_inc  = {1'b0, cur_sib} + 1'b1;
    // a bit length of zero wraps every sample, same as one
    assign sib_nxt  = (sib_inc >= {1'b0, r_spb}) ? '0 : sib_inc[SIB_W-1:0];

    // accumulators run freely; end of signal returns everything to time zero
    always_comb begin
        if (i_final_req) begin
            n_state = '0;
        end else begin
            n_state = {sib_nxt, held_eff,
                       cur_carrier + PHASE_BITS'(r_carrier_step),
                       cur_zero    + PHASE_BITS'(r_tone_zero_step),
                       cur_one     + PHASE_BITS'(r_tone_one_step)};
        end
    end

    // ------------------------------------------------------------------
    // keying: pick phase and gain, fold into the quarter wave
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] sel_phase;
    logic [1:0]            gain;
    logic [A-1:0]          addr;
    logic [1:0]            quad;
    logic [A-3:0]          kq;
    logic [A-2:0]          rom_idx;
    logic [MAG_W-1:0]      rom_mag;

    always_comb begin
        case (r_mode)
            MODE_ASK: begin
                sel_phase = cur_carrier;
                gain      = held_eff ? r_amp_one : r_amp_zero;
            end
            MODE_PSK: begin
                // half turn for bit one: flip the phase msb
                sel_phase = cur_carrier ^ {held_eff, {(PHASE_BITS-1){1'b0}}};
                gain      = 2'd1;
            end
            MODE_FSK: begin
                sel_phase = held_eff ? cur_one : cur_zero;
                gain      = 2'd1;
            end
            default: begin
                // unused mode gives silence
                sel_phase = cur_carrier;
                gain      = 2'd0;
            end
        endcase
    end

    assign addr    = sel_phase[PHASE_BITS-1 -: A];
    assign quad    = addr[A-1:A-2];
    assign kq      = addr[A-3:0];
    // odd quadrants read the table backwards
    assign rom_idx = quad[0] ? ({1'b1, {(A-2){1'b0}}} - {1'b0, kq}) : {1'b0, kq};

    apf_sine_rom #(
        .ADDR_BITS (A)
    ) u_rom (
        .i_clk (i_clk),
        .i_idx (rom_idx),
        .o_mag (rom_mag)
    );

    // rom stage sideband
    logic       r_v1;
    logic       r_s1_neg;
    logic [1:0] r_s1_gain;
    logic       r_s1_taken;
    logic       r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_neg   <= quad[1];
        r_s1_gain  <= gain;
        r_s1_taken <= taken;
        r_s1_last  <= i_final_req;
    end

    // gain and sign, straight into the output buffer
    logic [SAMPLE_W-1:0] mag17;
    t_out_item           s2_item;
    t_out_item           head;
    logic [CW-1:0]       fifo_count;

    assign mag17             = SAMPLE_W'(rom_mag) * SAMPLE_W'(r_s1_gain);
    assign s2_item.sample    = $signed(r_s1_neg ? (SAMPLE_W'(0) - mag17) : mag17);
    assign s2_item.bit_taken = r_s1_taken;
    assign s2_item.last      = r_s1_last;

    apf_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v1),
        .i_item  (s2_item),
        .i_pop   (o_out_valid && !i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (head),
        .o_count (fifo_count)
    );

    // room must exist for everything in flight plus a new item
    assign o_in_stall = (({1'b0, fifo_count} + (CW+1)'(r_v1)) >= (CW+1)'(FIFO_DEPTH));

    assign o_sample    = head.sample;
    assign o_bit_taken = head.bit_taken;
    assign o_last      = head.last;

endmodule

// ===== sv/apf_sine_rom.sv =====
// quarter-wave sine rom, q1.14 magnitudes, registered read
// depends on apf_pkg; contents are computed at elaboration
module apf_sine_rom
    import apf_pkg::*;
#(
    parameter int ADDR_BITS = SINE_ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic [ADDR_BITS-2:0] i_idx,
    output logic [MAG_W-1:0]     o_mag
);

    localparam int QBITS = ADDR_BITS - 2;
    localparam int DEPTH = (1 << QBITS) + 1;

    typedef logic [MAG_W-1:0] t_rom [DEPTH];

    // eleven-term taylor series in q30, then rounded to q1.14
    function automatic logic [MAG_W-1:0] quarter_sine(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (64'd1686629713 * 64'(k) + 64'((1 << QBITS) >> 1)) >> QBITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd342;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd420;
        sum  = sum + term;
        r    = (sum * 64'd16384 + (64'd1 << 29)) >> 30;
        return (r > 64'd16384) ? MAG_W'(16384) : r[MAG_W-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom t;
        for (int k = 0; k < DEPTH; k++) begin
            t[k] = quarter_sine(k);
        end
        return t;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [MAG_W-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        r_mag <= ROM[i_idx];
    end

    assign o_mag = r_mag;

endmodule

// ===== sv/apf_state_mem.sv =====
// one-entry state memory with a registered read and write forwarding
// no dependencies beyond apf_pkg defaults
module apf_state_mem
    import apf_pkg::*;
#(
    parameter int WIDTH = STATE_W_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [1];
    logic [WIDTH-1:0] r_rd;
    logic [WIDTH-1:0] r_fwd;
    logic             r_fwd_vld;

    // reset writes the cleared state word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr_en) begin
            r_mem[0] <= i_rst_n ? i_wr_data : '0;
        end
        r_rd <= r_mem[0];
    end

    // the registered read lags a write, so bypass the last write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b1;
            r_fwd     <= '0;
        end else begin
            r_fwd_vld <= i_wr_en;
            if (i_wr_en) begin
                r_fwd <= i_wr_data;
            end
        end
    end

    assign o_rd_data = r_fwd_vld ? r_fwd : r_rd;

endmodule

// ===== sv/apf_out_fifo.sv =====
// small output buffer of result items
// depends on apf_pkg for the item type
module apf_out_fifo
    import apf_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_out_item                    i_item,
    input  logic                         i_pop,
    output logic                         o_valid,
    output t_out_item                    o_item,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_out_item         r_buf [DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [CW-1:0]     r_count;
    logic              pop;

    assign pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_buf[r_rd];
    assign o_count = r_count;

endmodule

// ===== sv/apf_port_checker.sv =====
// port-level checks of the keying modulator, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module apf_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [16:0] o_sample,
    input logic               o_bit_taken,
    input logic               o_last
);

    // a stalled result stays offered
    `APF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a stalled result keeps its payload
    `APF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_sample) && $stable(o_bit_taken) && $stable(o_last))

    // the input only backs up behind a waiting result
    `APF_ASSERT_IMPL(a_stall_needs_out, i_clk, i_rst_n, o_in_stall, o_out_valid)

    // samples stay within three times full scale
    `APF_ASSERT_IMPL(a_sample_range, i_clk, i_rst_n, o_out_valid, (o_sample <= 17'sd49152) && (o_sample >= -17'sd49152))

endmodule

bind ask_psk_fsk_keying_modulator apf_port_checker u_apf_port_checker (.*);

// ===== dv/ask_psk_fsk_keying_modulator_tb.sv =====
// self-checking testbench for the ask / psk / fsk keying modulator
// needs apf_pkg and ask_psk_fsk_keying_modulator; predicts every sample with its own nco
module ask_psk_fsk_keying_modulator_tb;
    import apf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB      = PHASE_BITS_DEF;
    localparam int SAB     = SINE_ADDR_BITS_DEF;
    localparam int QUARTER = 1 << (SAB - 2);

    localparam logic [PB-1:0] HALF_TURN = {1'b1, {(PB - 1){1'b0}}};

    // keying modes as written to the mode register
    localparam logic [1:0] MODE_ASK  = 2'd0;
    localparam logic [1:0] MODE_PSK  = 2'd1;
    localparam logic [1:0] MODE_FSK  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // register indexes, byte address is four times the index
    localparam int REG_MODE            = 0;
    localparam int REG_SAMPLES_PER_BIT = 1;
    localparam int REG_CARRIER_STEP    = 2;
    localparam int REG_TONE_ZERO_STEP  = 3;
    localparam int REG_TONE_ONE_STEP   = 4;
    localparam int REG_AMP_ZERO        = 5;
    localparam int REG_AMP_ONE         = 6;
    localparam int REG_COUNT           = 7;

    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_MARK     = 25;

    typedef struct packed {
        logic data_bit;
        logic final_req;
    } t_bit_item;

    // clock, reset and block inputs, all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_data_bit  = 1'b0;
    logic        i_final_req = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [4:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;

    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic                       o_bit_taken;
    logic                       o_last;
    logic [31:0]                prdata;
    logic                       pready;

    // shadow of the configuration registers, at their reset values
    logic [1:0]    cfg_mode         = MODE_ASK;
    logic [15:0]   cfg_spb          = 16'd2000;
    logic [PB-1:0] cfg_carrier_step = 32'd4294967;
    logic [PB-1:0] cfg_tone0_step   = 32'd6442451;
    logic [PB-1:0] cfg_tone1_step   = 32'd8589935;
    logic [1:0]    cfg_amp0         = 2'd1;
    logic [1:0]    cfg_amp1         = 2'd2;

    // shadow of the modulator state
    int unsigned   pos_in_bit  = 0;
    logic          cur_bit     = 1'b0;
    logic [PB-1:0] carrier_acc = '0;
    logic [PB-1:0] tone0_acc   = '0;
    logic [PB-1:0] tone1_acc   = '0;

    int unsigned sine_q14 [0:QUARTER];

    t_bit_item bits_to_send [$];
    t_out_item samples_due [$];

    int send_idle_pct  = 29;
    int recv_stall_pct = 85;
    bit drain_wait     = 1'b0;
    bit drained_once   = 1'b0;
    int mismatches     = 0;
    int idle_cycles    = 0;

    ask_psk_fsk_keying_modulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_bit  (i_data_bit),
        .i_final_req (i_final_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .o_bit_taken (o_bit_taken),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // quarter-wave sine table in q1.14: eleven-term taylor series in q30, rounded half up
    initial begin : build_sine
        longint unsigned x, x2, term, sum, r;
        for (int k = 0; k <= QUARTER; k++) begin
            x = (64'd1686629713 * longint'(k) + (QUARTER >> 1)) >> (SAB - 2);
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 10; n++) begin
                term = (term * x2) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            r = (sum * 64'd16384 + (64'd1 << 29)) >> 30;
            sine_q14[k] = (r > 64'd16384) ? 16384 : int'(r);
        end
    end

    // one sample of the modulator: take the bit at a bit boundary, key the sine,
    // then step all three accumulators and the bit position, or clear them at end of signal
    task automatic keyed_sample(input logic data_bit, input logic final_req);
        t_out_item     due;
        logic [PB-1:0] ph;
        logic [SAB-1:0] addr;
        int unsigned   k, idx, mag;
        due.bit_taken = (pos_in_bit == 0);
        if (due.bit_taken) begin
            cur_bit = data_bit;
        end
        ph = carrier_acc;
        case (cfg_mode)
            MODE_PSK: begin
                ph = carrier_acc + (cur_bit ? HALF_TURN : '0);
            end
            MODE_FSK: begin
                ph = cur_bit ? tone1_acc : tone0_acc;
            end
            default: ;
        endcase
        // top address bits pick the quadrant, odd quadrants read the table backwards
        addr = ph[PB-1 -: SAB];
        k = addr[SAB-3:0];
        idx = addr[SAB-2] ? QUARTER - k : k;
        if (cfg_mode == MODE_ASK) begin
            mag = sine_q14[idx] * (cur_bit ? cfg_amp1 : cfg_amp0);
        end else if (cfg_mode == MODE_NONE) begin
            mag = 0;
        end else begin
            mag = sine_q14[idx];
        end
        due.sample = SAMPLE_W'(mag);
        if (addr[SAB-1]) begin
            due.sample = -due.sample;
        end
        due.last = final_req;
        carrier_acc = carrier_acc + cfg_carrier_step;
        tone0_acc = tone0_acc + cfg_tone0_step;
        tone1_acc = tone1_acc + cfg_tone1_step;
        // a bit length of zero wraps at once, like a length of one
        pos_in_bit = pos_in_bit + 1;
        if (pos_in_bit >= cfg_spb) begin
            pos_in_bit = 0;
        end
        // end of signal: next item starts again at time zero
        if (final_req) begin
            pos_in_bit = 0;
            cur_bit = 1'b0;
            carrier_acc = '0;
            tone0_acc = '0;
            tone1_acc = '0;
        end
        samples_due = {samples_due, due};
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input int idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // indexes past the last register are dropped
        case (idx)
            REG_MODE:            cfg_mode = value[1:0];
            REG_SAMPLES_PER_BIT: cfg_spb = value[15:0];
            REG_CARRIER_STEP:    cfg_carrier_step = value;
            REG_TONE_ZERO_STEP:  cfg_tone0_step = value;
            REG_TONE_ONE_STEP:   cfg_tone1_step = value;
            REG_AMP_ZERO:        cfg_amp0 = value[1:0];
            REG_AMP_ONE:         cfg_amp1 = value[1:0];
            default: ;
        endcase
    endtask

    task automatic push_bit(input logic data_bit, input logic final_req);
        t_bit_item it;
        it.data_bit = data_bit;
        it.final_req = final_req;
        bits_to_send = {bits_to_send, it};
    endtask

    // every item sent and every sample back, then a settling wait for the pipeline
    task automatic wait_idle();
        while (bits_to_send.size() != 0 || i_in_valid || samples_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // phase steps favor the corners: stopped, largest, half turn, slow
    function automatic logic [31:0] pick_step();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return HALF_TURN;
            3: return 32'($urandom_range(32'h0100_0000));
            default: return $urandom();
        endcase
    endfunction

    // sender: a held item stays until taken, the next one goes out after a random gap
    always @(posedge i_clk) begin : bit_sender
        t_bit_item nxt;
        bit        took;
        if (i_rst_n) begin
            took = i_in_valid && !o_in_stall;
            if (took) begin
                keyed_sample(i_data_bit, i_final_req);
            end
            if (!i_in_valid || !o_in_stall) begin
                // now and then hold off until every sample in flight is back,
                // once for sure in the middle of a long stream
                if (!drain_wait && bits_to_send.size() != 0
                        && ($urandom_range(299) == 0
                            || (!drained_once && bits_to_send.size() == DRAIN_MARK))) begin
                    drain_wait = 1'b1;
                    drained_once = 1'b1;
                end else if (drain_wait && !took && samples_due.size() == 0) begin
                    drain_wait = 1'b0;
                end
                if (!drain_wait && bits_to_send.size() != 0
                        && $urandom_range(99) >= send_idle_pct) begin
                    nxt = bits_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_bit <= nxt.data_bit;
                    i_final_req <= nxt.final_req;
                end else begin
                    // payload wanders while valid is low
                    i_in_valid <= 1'b0;
                    i_data_bit <= 1'($urandom());
                    i_final_req <= 1'($urandom());
                end
            end
        end
    end

    // receiver: random stall, compare each accepted sample against the oldest prediction
    always @(posedge i_clk) begin : sample_checker
        t_out_item due;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (samples_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected sample %0d bit_taken %0b last %0b",
                                 o_sample, o_bit_taken, o_last);
                    end
                end else begin
                    due = samples_due.pop_front();
                    if (o_sample !== due.sample || o_bit_taken !== due.bit_taken
                            || o_last !== due.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display({"sample exp %0d got %0d, bit_taken exp %0b got %0b,",
                                      " last exp %0b got %0b"},
                                     due.sample, o_sample, due.bit_taken, o_bit_taken,
                                     due.last, o_last);
                        end
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            // watchdog: any handshake or register write counts as progress
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (psel && penable && pwrite && pready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [1:0]  m;
        logic [15:0] spb;
        int          n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: ask with gains one and two, long bits
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b0);
        wait_idle();

        // ask, zero bit length so every sample takes a bit, quarter-turn steps,
        // zero gain against full gain, end of signal in the middle
        write_reg(REG_MODE, MODE_ASK);
        write_reg(REG_SAMPLES_PER_BIT, 32'd0);
        write_reg(REG_CARRIER_STEP, 32'h4000_0000);
        write_reg(REG_AMP_ZERO, 32'd0);
        write_reg(REG_AMP_ONE, 32'd3);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b1);
        push_bit(1'b1, 1'b0);
        wait_idle();

        // psk with the largest carrier step
        write_reg(REG_MODE, MODE_PSK);
        write_reg(REG_SAMPLES_PER_BIT, 32'd1);
        write_reg(REG_CARRIER_STEP, 32'hFFFF_FFFF);
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);
        wait_idle();

        // fsk: stopped tone for zero, half-turn tone for one, three samples per bit
        write_reg(REG_MODE, MODE_FSK);
        write_reg(REG_SAMPLES_PER_BIT, 32'd3);
        write_reg(REG_TONE_ZERO_STEP, 32'h0);
        write_reg(REG_TONE_ONE_STEP, HALF_TURN);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b1);
        wait_idle();

        // unused mode gives silence, a write past the last register is dropped,
        // longest bit period
        write_reg(REG_MODE, MODE_NONE);
        write_reg(REG_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_SAMPLES_PER_BIT, 32'h0000_FFFF);
        push_bit(1'b1, 1'b0);
        push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b1);
        wait_idle();

        // random segments under three idle patterns
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 29;
                    recv_stall_pct = 85;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_stall_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 6; seg++) begin
                m = ($urandom_range(9) == 0) ? MODE_NONE : 2'($urandom_range(2));
                case ($urandom_range(9))
                    0: spb = 16'd0;
                    1: spb = 16'hFFFF;
                    2: spb = 16'($urandom_range(100, 4000));
                    default: spb = 16'($urandom_range(1, 8));
                endcase
                // narrow registers get junk above their width
                write_reg(REG_MODE, ($urandom() & ~32'h3) | 32'(m));
                write_reg(REG_SAMPLES_PER_BIT, ($urandom() & 32'hFFFF_0000) | 32'(spb));
                write_reg(REG_CARRIER_STEP, pick_step());
                write_reg(REG_TONE_ZERO_STEP, pick_step());
                write_reg(REG_TONE_ONE_STEP, pick_step());
                write_reg(REG_AMP_ZERO, $urandom());
                write_reg(REG_AMP_ONE, $urandom());
                // long signals with the occasional end of signal
                n = $urandom_range(40, 88);
                for (int i = 0; i < n; i++) begin
                    push_bit(1'($urandom()), ($urandom_range(99) < 3));
                end
                wait_idle();
            end
        end

        if (mismatches == 0 && samples_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
